### rtl/ibcs_pkg.sv
`timescale 1ns / 1ps

package ibcs_pkg;

  // Register widths
  localparam int SETTLE_W = 24;
  localparam int HALF_W   = 16;
  localparam int POLL_W   = 24;
  localparam int COUNT_W  = 5;
  localparam int TICK_W   = 24;
  localparam int CFG_DW   = 24;
  localparam int CFG_AW   = 3;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_SETTLE     = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HALF       = 3'd1;
  localparam logic [CFG_AW-1:0] REG_POLL       = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_PULSES = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MAX_POLLS  = 3'd4;

  // Register reset values
  localparam logic [SETTLE_W-1:0] SETTLE_RST     = 24'd2000000;
  localparam logic [HALF_W-1:0]   HALF_RST       = 16'd10;
  localparam logic [POLL_W-1:0]   POLL_RST       = 24'd100000;
  localparam logic [COUNT_W-1:0]  MAX_PULSES_RST = 5'd20;
  localparam logic [COUNT_W-1:0]  MAX_POLLS_RST  = 5'd20;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_SETTLE    = 4'd1,
    PH_LOW       = 4'd2,
    PH_HIGH      = 4'd3,
    PH_STRETCH   = 4'd4,
    PH_STOP_LOW  = 4'd5,
    PH_STOP_HIGH = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SCL_LOW = 2'd1,
    ST_STRETCH = 2'd2,
    ST_SDA_LOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle_ticks;
    logic [HALF_W-1:0]   half_period_ticks;
    logic [POLL_W-1:0]   stretch_poll_ticks;
    logic [COUNT_W-1:0]  max_pulses;
    logic [COUNT_W-1:0]  max_stretch_polls;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [TICK_W-1:0]  tick_count;
    logic [COUNT_W-1:0] pulses_left;
    logic [COUNT_W-1:0] polls_left;
    status_t            last_status;
  } seq_state_t;

  typedef struct packed {
    logic    scl_drive_low;
    logic    sda_drive_low;
    logic    busy_res;
    logic    done_res;
    status_t status;
  } result_t;

endpackage

### rtl/ibcs_cfg.sv
`timescale 1ns / 1ps

module ibcs_cfg import ibcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output cfg_t              cfg
);

  // Register file, each write truncated to the register width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks       <= SETTLE_RST;
      cfg.half_period_ticks  <= HALF_RST;
      cfg.stretch_poll_ticks <= POLL_RST;
      cfg.max_pulses         <= MAX_PULSES_RST;
      cfg.max_stretch_polls  <= MAX_POLLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETTLE:     cfg.settle_ticks       <= cfg_data[SETTLE_W-1:0];
        REG_HALF:       cfg.half_period_ticks  <= cfg_data[HALF_W-1:0];
        REG_POLL:       cfg.stretch_poll_ticks <= cfg_data[POLL_W-1:0];
        REG_MAX_PULSES: cfg.max_pulses         <= cfg_data[COUNT_W-1:0];
        REG_MAX_POLLS:  cfg.max_stretch_polls  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/ibcs_step.sv
`timescale 1ns / 1ps

module ibcs_step import ibcs_pkg::*; (
  input  cfg_t       cfg,
  input  seq_state_t cur,
  input  logic       req_type,
  input  logic       sda_in,
  input  logic       scl_in,
  output seq_state_t nxt,
  output result_t    res
);

  logic    finished;
  logic    do_check;
  logic    check_sda;
  logic    do_finish;
  status_t fin_status;

  // Next state
  always_comb begin
    nxt        = cur;
    do_check   = 1'b0;
    check_sda  = 1'b0;
    do_finish  = 1'b0;
    fin_status = ST_OK;

    if (req_type) begin
      // start, ignored while a run is under way
      if (cur.phase == PH_IDLE) begin
        nxt.last_status = ST_OK;
        nxt.pulses_left = '0;
        nxt.polls_left  = '0;
        nxt.phase       = PH_SETTLE;
        nxt.tick_count  = cfg.settle_ticks;
      end
    end else if (cur.phase != PH_IDLE) begin
      if (cur.tick_count > TICK_W'(1)) begin
        nxt.tick_count = cur.tick_count - TICK_W'(1);
      end else begin
        // wait over: act on the line samples of this tick
        case (cur.phase)
          PH_SETTLE: begin
            if (!scl_in) begin
              do_finish  = 1'b1;
              fin_status = ST_SCL_LOW;
            end else if (sda_in) begin
              do_finish  = 1'b1;
              fin_status = ST_OK;
            end else begin
              nxt.pulses_left = cfg.max_pulses;
              do_check        = 1'b1;
              check_sda       = 1'b0;
            end
          end
          PH_LOW: begin
            nxt.phase      = PH_HIGH;
            nxt.tick_count = TICK_W'(cfg.half_period_ticks);
          end
          PH_HIGH: begin
            if (scl_in) begin
              do_check  = 1'b1;
              check_sda = sda_in;
            end else if (cfg.max_stretch_polls == '0) begin
              nxt.polls_left = '0;
              do_finish      = 1'b1;
              fin_status     = ST_STRETCH;
            end else begin
              nxt.polls_left = cfg.max_stretch_polls - COUNT_W'(1);
              nxt.phase      = PH_STRETCH;
              nxt.tick_count = cfg.stretch_poll_ticks;
            end
          end
          PH_STRETCH: begin
            if (scl_in) begin
              do_check  = 1'b1;
              check_sda = sda_in;
            end else if (cur.polls_left == '0) begin
              do_finish  = 1'b1;
              fin_status = ST_STRETCH;
            end else begin
              nxt.polls_left = cur.polls_left - COUNT_W'(1);
              nxt.phase      = PH_STRETCH;
              nxt.tick_count = cfg.stretch_poll_ticks;
            end
          end
          PH_STOP_LOW: begin
            nxt.phase      = PH_STOP_HIGH;
            nxt.tick_count = TICK_W'(cfg.half_period_ticks);
          end
          default: begin
            // end of stop condition, or a phase code with no meaning
            do_finish  = 1'b1;
            fin_status = ST_OK;
          end
        endcase

        // SCL is high again: SDA decides stop, fail or another pulse
        if (do_check) begin
          if (check_sda) begin
            nxt.phase      = PH_STOP_LOW;
            nxt.tick_count = TICK_W'(cfg.half_period_ticks);
          end else if (nxt.pulses_left == '0) begin
            do_finish  = 1'b1;
            fin_status = ST_SDA_LOW;
          end else begin
            nxt.pulses_left = nxt.pulses_left - COUNT_W'(1);
            nxt.phase       = PH_LOW;
            nxt.tick_count  = TICK_W'(cfg.half_period_ticks);
          end
        end

        if (do_finish) begin
          nxt.phase       = PH_IDLE;
          nxt.tick_count  = '0;
          nxt.last_status = fin_status;
        end
      end
    end
  end

  assign finished = do_finish;

  // Outputs, taken from the state after the item
  always_comb begin
    res.scl_drive_low = (nxt.phase == PH_LOW);
    res.sda_drive_low = (nxt.phase == PH_STOP_LOW);
    res.busy_res      = (nxt.phase != PH_IDLE);
    res.done_res      = finished;
    res.status        = nxt.last_status;
  end

endmodule

### rtl/i2c_bus_clear_sequencer_core.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    req_type, sda_in, scl_in
// out       out_valid / out_ready  scl_drive_low, sda_drive_low, busy_res, done_res, status
// cfg       cfg_we                 cfg_index, cfg_data
//
// One item per cycle unless out stalls: the state update and result come from one
// pass of next-state logic and land in the state and result registers on the same edge.
// in_ready is high whenever the result register is empty or being taken.
// A stall on out holds the result and the state; no item is lost.
// rst is synchronous: phase idle, counters zero, registers to their defaults.

module i2c_bus_clear_sequencer_core import ibcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic              sda_in,
  input  logic              scl_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              scl_drive_low,
  output logic              sda_drive_low,
  output logic              busy_res,
  output logic              done_res,
  output logic [1:0]        status,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;
  result_t    res_next;
  result_t    res;
  logic       accept;

  ibcs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ibcs_step u_step (
    .cfg      (cfg),
    .cur      (state),
    .req_type (req_type),
    .sda_in   (sda_in),
    .scl_in   (scl_in),
    .nxt      (state_next),
    .res      (res_next)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_IDLE;
      state.tick_count  <= '0;
      state.pulses_left <= '0;
      state.polls_left  <= '0;
      state.last_status <= ST_OK;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign scl_drive_low = res.scl_drive_low;
  assign sda_drive_low = res.sda_drive_low;
  assign busy_res      = res.busy_res;
  assign done_res      = res.done_res;
  assign status        = res.status;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ibcs_pkg::*;

  localparam int   QUIET_LIMIT  = 2000;
  localparam int   DRAIN_CYCLES = 4;
  localparam int   MAX_REPORTS  = 100;
  localparam int   IDLE_PCT     = 36;
  localparam int   LONG_TICKS   = 64;
  localparam logic REQ_TICK     = 1'b0;
  localparam logic REQ_START    = 1'b1;

  logic              clk;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic              req_type      = REQ_TICK;
  logic              sda_in        = 1'b1;
  logic              scl_in        = 1'b1;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic              scl_drive_low;
  logic              sda_drive_low;
  logic              busy_res;
  logic              done_res;
  logic [1:0]        status;
  logic              cfg_we        = 1'b0;
  logic [CFG_AW-1:0] cfg_index     = REG_SETTLE;
  logic [CFG_DW-1:0] cfg_data      = '0;

  int idle_pct     = IDLE_PCT;
  int fault_count  = 0;
  int quiet_cycles = 0;

  // Local copy of the register file
  logic [SETTLE_W-1:0] settle_cfg = SETTLE_RST;
  logic [HALF_W-1:0]   half_cfg   = HALF_RST;
  logic [POLL_W-1:0]   poll_cfg   = POLL_RST;
  logic [COUNT_W-1:0]  pulses_cfg = MAX_PULSES_RST;
  logic [COUNT_W-1:0]  polls_cfg  = MAX_POLLS_RST;

  // Sequencer state as the predictor sees it
  phase_t             seq_phase   = PH_IDLE;
  logic [TICK_W-1:0]  wait_ticks  = '0;
  logic [COUNT_W-1:0] pulses_left = '0;
  logic [COUNT_W-1:0] polls_left  = '0;
  status_t            last_status = ST_OK;
  logic               run_done    = 1'b0;

  result_t pending_results[$];

  i2c_bus_clear_sequencer_core u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void end_run(status_t st);
    seq_phase   = PH_IDLE;
    wait_ticks  = '0;
    last_status = st;
    run_done    = 1'b1;
  endfunction

  function automatic void start_wait(phase_t ph, logic [TICK_W-1:0] n);
    seq_phase  = ph;
    wait_ticks = n;
  endfunction

  // SCL is back high: either SDA is free and we go to the stop, or pulse again
  function automatic void sda_decision(logic sda);
    if (sda) begin
      start_wait(PH_STOP_LOW, TICK_W'(half_cfg));
    end else if (pulses_left == '0) begin
      end_run(ST_SDA_LOW);
    end else begin
      pulses_left--;
      start_wait(PH_LOW, TICK_W'(half_cfg));
    end
  endfunction

  // SCL still held by a slave: poll again or give up
  function automatic void stretch_poll();
    if (polls_left == '0) begin
      end_run(ST_STRETCH);
    end else begin
      polls_left--;
      start_wait(PH_STRETCH, poll_cfg);
    end
  endfunction

  function automatic result_t next_bus_clear_result(logic req, logic sda, logic scl);
    result_t r;
    run_done = 1'b0;
    if (req == REQ_START) begin
      if (seq_phase == PH_IDLE) begin
        last_status = ST_OK;
        pulses_left = '0;
        polls_left  = '0;
        start_wait(PH_SETTLE, settle_cfg);
      end
    end else if (seq_phase != PH_IDLE) begin
      if (wait_ticks > 1) begin
        wait_ticks--;
      end else begin
        case (seq_phase)
          PH_SETTLE: begin
            if (!scl) end_run(ST_SCL_LOW);
            else if (sda) end_run(ST_OK);
            else begin
              pulses_left = pulses_cfg;
              sda_decision(1'b0);
            end
          end
          PH_LOW: start_wait(PH_HIGH, TICK_W'(half_cfg));
          PH_HIGH: begin
            if (scl) sda_decision(sda);
            else begin
              polls_left = polls_cfg;
              stretch_poll();
            end
          end
          PH_STRETCH: begin
            if (scl) sda_decision(sda);
            else stretch_poll();
          end
          PH_STOP_LOW: start_wait(PH_STOP_HIGH, TICK_W'(half_cfg));
          default: end_run(ST_OK);
        endcase
      end
    end
    r.scl_drive_low = (seq_phase == PH_LOW);
    r.sda_drive_low = (seq_phase == PH_STOP_LOW);
    r.busy_res      = (seq_phase != PH_IDLE);
    r.done_res      = run_done;
    r.status        = last_status;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report(string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("tb: mismatch: %s", msg);
  endtask

  // One item on the input channel, with a random hold-off before it
  task automatic send_item(logic req, logic sda, logic scl);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    req_type <= req;
    sda_in   <= sda;
    scl_in   <= scl;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(next_bus_clear_result(req, sda, scl));
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Tick with both lines free until the current run has ended
  task automatic finish_run();
    while (seq_phase != PH_IDLE) send_item(REQ_TICK, 1'b1, 1'b1);
  endtask

  function automatic logic [CFG_DW-1:0] with_junk(logic [CFG_DW-1:0] v, int w);
    return v | (CFG_DW'($urandom) << w);
  endfunction

  // Writes all five registers plus one unmapped index, which must be ignored
  task automatic load_settings(logic [CFG_DW-1:0] settle, logic [CFG_DW-1:0] half,
                               logic [CFG_DW-1:0] poll, logic [CFG_DW-1:0] pulses,
                               logic [CFG_DW-1:0] polls);
    logic [CFG_DW-1:0] vals[5];
    logic [CFG_AW-1:0] regs[5];
    vals = '{settle, half, poll, pulses, polls};
    regs = '{REG_SETTLE, REG_HALF, REG_POLL, REG_MAX_PULSES, REG_MAX_POLLS};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_POLLS + CFG_AW'($urandom_range(1, 2));
    cfg_data  <= CFG_DW'($urandom);
    @(posedge clk);
    cfg_we     <= 1'b0;
    settle_cfg = settle[SETTLE_W-1:0];
    half_cfg   = half[HALF_W-1:0];
    poll_cfg   = poll[POLL_W-1:0];
    pulses_cfg = pulses[COUNT_W-1:0];
    polls_cfg  = polls[COUNT_W-1:0];
  endtask

  // ---------------------------------------------------------------- tests

  // Idle ticks, SCL stuck low, a start while busy, both lines free at once
  task automatic tick_and_fault_test();
    wait_idle();
    load_settings(0, 1, 1, 1, 1);
    send_item(REQ_TICK, 1'b0, 1'b0);
    send_item(REQ_TICK, 1'b1, 1'b1);
    send_item(REQ_START, 1'b0, 1'b0);
    send_item(REQ_TICK, 1'b1, 1'b0);
    send_item(REQ_START, 1'b1, 1'b1);
    send_item(REQ_START, 1'b0, 1'b0);
    send_item(REQ_TICK, 1'b1, 1'b1);
  endtask

  // One pulse frees SDA and a stop follows; then a stretch that times out
  task automatic pulse_and_stretch_test();
    send_item(REQ_START, 1'b1, 1'b1);
    send_item(REQ_TICK, 1'b0, 1'b1);
    send_item(REQ_TICK, 1'b0, 1'b0);
    send_item(REQ_TICK, 1'b1, 1'b1);
    send_item(REQ_TICK, 1'b0, 1'b0);
    send_item(REQ_TICK, 1'b0, 1'b0);
    send_item(REQ_START, 1'b0, 1'b0);
    send_item(REQ_TICK, 1'b0, 1'b1);
    send_item(REQ_TICK, 1'b1, 1'b1);
    send_item(REQ_TICK, 1'b0, 1'b0);
    send_item(REQ_TICK, 1'b1, 1'b0);
  endtask

  // No pulses allowed, then no stretch polls allowed
  task automatic zero_limit_test();
    wait_idle();
    load_settings(1, 1, 1, 0, 0);
    send_item(REQ_START, 1'b1, 1'b1);
    send_item(REQ_TICK, 1'b0, 1'b1);
    wait_idle();
    load_settings(2, 2, 1, 1, 0);
    send_item(REQ_START, 1'b0, 1'b1);
    send_item(REQ_TICK, 1'b0, 1'b1);
    send_item(REQ_TICK, 1'b0, 1'b1);
    send_item(REQ_TICK, 1'b1, 1'b0);
    send_item(REQ_TICK, 1'b0, 1'b1);
    send_item(REQ_TICK, 1'b1, 1'b1);
    send_item(REQ_TICK, 1'b0, 1'b0);
  endtask

  // Random runs over several register settings
  task automatic random_run_test();
    int  live;
    int  sda_low_pct;
    int  scl_low_pct;
    logic req;
    for (int s = 0; s < 6; s++) begin
      finish_run();
      wait_idle();
      if (s == 0) begin
        load_settings(0, 1, 1, 31, 31);
      end else begin
        load_settings(CFG_DW'($urandom_range(0, 8)),
                      with_junk(CFG_DW'($urandom_range(1, 4)), HALF_W),
                      CFG_DW'($urandom_range(1, 4)),
                      with_junk(CFG_DW'($urandom_range(0, 31)), COUNT_W),
                      with_junk(CFG_DW'($urandom_range(0, 31)), COUNT_W));
      end
      sda_low_pct = $urandom_range(20, 90);
      scl_low_pct = $urandom_range(3, 30);
      live = 0;
      while (live < 85) begin
        if (seq_phase == PH_IDLE) req = ($urandom_range(99) < 75);
        else req = ($urandom_range(99) < 3);
        if (req == REQ_START || seq_phase != PH_IDLE) live++;
        send_item(req, $urandom_range(99) >= sda_low_pct,
                  $urandom_range(99) >= scl_low_pct);
      end
    end
  endtask

  // Widest half period with no idling on either side; the run is left part
  // way through its first low half
  task automatic long_half_period_test();
    finish_run();
    wait_idle();
    idle_pct = 0;
    load_settings(0, 24'h00FFFF, 1, 1, 0);
    send_item(REQ_START, 1'b1, 1'b0);
    send_item(REQ_TICK, 1'b0, 1'b1);
    repeat (LONG_TICKS) send_item(REQ_TICK, 1'b0, 1'b1);
    idle_pct = IDLE_PCT;
  endtask

  // Largest values written while a run is under way: the low half already
  // loaded keeps its count, and starts are ignored
  task automatic long_wait_test();
    wait_idle();
    load_settings(24'hFFFFFF, 24'h00FFFF, 24'hFFFFFF, 31, 31);
    send_item(REQ_START, 1'b0, 1'b1);
    repeat (40) send_item(REQ_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
    send_item(REQ_START, 1'b1, 1'b1);
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    out_ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (scl_drive_low !== want.scl_drive_low)
          report($sformatf("scl_drive_low expected %0b, got %0b",
                           want.scl_drive_low, scl_drive_low));
        if (sda_drive_low !== want.sda_drive_low)
          report($sformatf("sda_drive_low expected %0b, got %0b",
                           want.sda_drive_low, sda_drive_low));
        if (busy_res !== want.busy_res)
          report($sformatf("busy_res expected %0b, got %0b", want.busy_res, busy_res));
        if (done_res !== want.done_res)
          report($sformatf("done_res expected %0b, got %0b", want.done_res, done_res));
        if (status !== want.status)
          report($sformatf("status expected %0d, got %0d", want.status, status));
      end
    end
  end

  // Watchdog: too long with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    tick_and_fault_test();
    pulse_and_stretch_test();
    zero_limit_test();
    random_run_test();
    long_half_period_test();
    long_wait_test();
    wait_idle();
    if (fault_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
